@@ src/rbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared types, codes and the RGB565 blend function of the blit/fill engine.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int COORD_W = 10;
  localparam int RUN_W   = 11;
  localparam int PIX_W   = 16;
  localparam int ALPHA_W = 8;
  localparam int PROD_W  = 22;
  localparam int SUM_W   = 23;
  localparam int WCNT_W  = 21;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 1;

  localparam logic [RUN_W-1:0]   MAX_RUN     = 11'd1024;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'd255;
  localparam logic [CFG_W-1:0]   STRIDE_RST  = 11'd320;
  localparam logic [CFG_W-1:0]   ROWS_RST    = 11'd240;

  localparam logic [CIDX_W-1:0] REG_STRIDE = 1'b0;
  localparam logic [CIDX_W-1:0] REG_ROWS   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOR    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOBLIT = 2'd2;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_FILL  = 3'd1,
    OP_AFILL = 3'd2,
    OP_BBEG  = 3'd3,
    OP_BPIX  = 3'd4,
    OP_CLEAR = 3'd5,
    OP_READ  = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic chk;
    logic wr;
    logic rd_cap;
    logic blit_set;
    logic blit_adv;
    logic no_blit;
    logic clr_start;
    logic clr_step;
    logic loop_adv;
    logic out_load;
  } rbf_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic zero_fill;
    logic fill_last;
    logic blit_active;
    logic skip_px;
    logic clr_empty;
    logic clr_last;
    logic out_valid;
  } rbf_stat_t;

  // one channel: (f*a + b*(255-a)) / 255, divide as (x + (x>>8) + 1) >> 8
  function automatic logic [5:0] blend_ch(input logic [5:0] f, input logic [5:0] b,
                                          input logic [ALPHA_W-1:0] a);
    logic [15:0] x;
    logic [15:0] q;
    x = 16'(f) * 16'(a) + 16'(b) * 16'(ALPHA_FULL - a);
    q = (x + (x >> 8) + 16'd1) >> 8;
    return q[5:0];
  endfunction

  function automatic logic [PIX_W-1:0] blend565(input logic [PIX_W-1:0] fg,
                                                input logic [ALPHA_W-1:0] a,
                                                input logic [PIX_W-1:0] bg);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    r = blend_ch({1'b0, fg[15:11]}, {1'b0, bg[15:11]}, a);
    g = blend_ch(fg[10:5], bg[10:5], a);
    b = blend_ch({1'b0, fg[4:0]}, {1'b0, bg[4:0]}, a);
    return {r[4:0], g, b[4:0]};
  endfunction

endpackage

@@ src/rbf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_ctrl
// Command sequencer: decodes each item and walks each pixel access through multiply, check, access steps.
// ----------------------------------------------------------------------------
module rbf_ctrl
  import rbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  input  rbf_stat_t stat,
  output rbf_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DEC    = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_CHK    = 9'b000001000,
    S_WR     = 9'b000010000,
    S_RD     = 9'b000100000,
    S_CSTART = 9'b001000000,
    S_CLR    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.op)
          OP_SET, OP_CLEAR, OP_READ: state_nxt = S_MUL;
          OP_FILL, OP_AFILL: state_nxt = stat.zero_fill ? S_DONE : S_MUL;
          OP_BBEG: begin
            cmd.blit_set = 1'b1;
            state_nxt    = S_DONE;
          end
          OP_BPIX: begin
            if (!stat.blit_active) begin
              cmd.no_blit = 1'b1;
              state_nxt   = S_DONE;
            end else if (stat.skip_px) begin
              cmd.blit_adv = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_MUL;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = (stat.op == OP_CLEAR) ? S_CSTART : S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = (stat.op == OP_READ) ? S_RD : S_WR;
      end
      S_RD: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_DONE;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (stat.op == OP_BPIX) begin
          cmd.blit_adv = 1'b1;
          state_nxt    = S_DONE;
        end else if ((stat.op == OP_FILL || stat.op == OP_AFILL) && !stat.fill_last) begin
          cmd.loop_adv = 1'b1;
          state_nxt    = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CSTART: begin
        cmd.clr_start = 1'b1;
        state_nxt     = stat.clr_empty ? S_DONE : S_CLR;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DEC))
    else $error("accepted item did not reach decode");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!stat.out_valid || out_ready))
    else $error("result loaded over a waiting result");

  a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && stat.clr_last) |=> (state_r == S_DONE))
    else $error("clear sweep overran its end");

endmodule

@@ src/rbf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_datapath
// Frame store, item and blit registers, address math, blend and result.
// ----------------------------------------------------------------------------
module rbf_datapath
  import rbf_pkg::*;
#(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_command,
  input  logic [COORD_W-1:0]   in_pos_x,
  input  logic [COORD_W-1:0]   in_pos_y,
  input  logic [RUN_W-1:0]     in_rect_width,
  input  logic [RUN_W-1:0]     in_rect_height,
  input  logic [PIX_W-1:0]     in_pixel_color,
  input  logic [ALPHA_W-1:0]   in_alpha,
  input  logic [PIX_W-1:0]     in_key_color,
  input  logic                 cfg_we,
  input  logic [CIDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  rbf_cmd_t             cmd,
  output rbf_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_read_value,
  output logic [STAT_W-1:0]    out_status,
  output logic [WCNT_W-1:0]    out_pixels_written
);

  localparam int DEPTH = SCREEN_W * SCREEN_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [PIX_W-1:0] mem [DEPTH];

  logic [CFG_W-1:0]   stride_r, rows_r;
  op_t                op_r;
  logic [COORD_W-1:0] px_r, py_r;
  logic [RUN_W-1:0]   w_r, h_r;
  logic [PIX_W-1:0]   color_r, key_r;
  logic [ALPHA_W-1:0] a_r;

  logic [COORD_W-1:0] bx_r, by_r;
  logic [RUN_W-1:0]   bw_r, bh_r, bc_r, br_r;
  logic [PIX_W-1:0]   bkey_r;
  logic [ALPHA_W-1:0] bwt_r;
  logic               bact_r;

  logic [RUN_W-1:0]   c_r, r_r;
  logic [PROD_W-1:0]  prod_r;
  logic [SUM_W-1:0]   addr_r;
  logic               inr_r;
  logic [PIX_W-1:0]   rd_r;
  logic [CW-1:0]      n_r, clr_r;

  logic [PIX_W-1:0]   res_rv_r;
  logic [STAT_W-1:0]  res_st_r;
  logic [WCNT_W-1:0]  res_wr_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_rv_r;
  logic [STAT_W-1:0]  out_st_r;
  logic [WCNT_W-1:0]  out_wr_r;

  logic [RUN_W-1:0]   col_sel, row_sel;
  logic [SUM_W-1:0]   addr_sum;
  logic [ALPHA_W-1:0] wt_sel;
  logic [RUN_W-1:0]   bc_inc, br_inc;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [PIX_W-1:0]   mem_wd;

  always_comb begin
    if (op_r == OP_BPIX) begin
      col_sel = RUN_W'(bx_r) + bc_r;
      row_sel = RUN_W'(by_r) + br_r;
    end else begin
      col_sel = RUN_W'(px_r) + c_r;
      row_sel = RUN_W'(py_r) + r_r;
    end
    unique case (op_r)
      OP_AFILL: wt_sel = a_r;
      OP_BPIX:  wt_sel = bwt_r;
      default:  wt_sel = ALPHA_FULL;
    endcase
  end

  assign addr_sum = SUM_W'(prod_r) + SUM_W'(col_sel);
  assign bc_inc   = bc_r + RUN_W'(1);
  assign br_inc   = br_r + RUN_W'(1);

  assign mem_we = (cmd.wr && inr_r) || cmd.clr_step;
  assign mem_wa = cmd.clr_step ? clr_r[AW-1:0] : addr_r[AW-1:0];
  assign mem_wd = cmd.clr_step ? '0 :
                  (wt_sel == ALPHA_FULL) ? color_r : blend565(color_r, wt_sel, rd_r);

  // frame store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.chk) rd_r <= mem[addr_sum[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RST;
      rows_r   <= ROWS_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_STRIDE) stride_r <= cfg_wdata;
      if (cfg_index == REG_ROWS)   rows_r   <= cfg_wdata;
    end
  end

  // latched item and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_NONE;
    end else if (cmd.load) begin
      op_r <= op_t'(in_command);
    end
    if (cmd.load) begin
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      w_r     <= (in_rect_width  > MAX_RUN) ? MAX_RUN : in_rect_width;
      h_r     <= (in_rect_height > MAX_RUN) ? MAX_RUN : in_rect_height;
      color_r <= in_pixel_color;
      a_r     <= in_alpha;
      key_r   <= in_key_color;
      c_r     <= '0;
      r_r     <= '0;
    end else if (cmd.loop_adv) begin
      if (c_r == w_r - RUN_W'(1)) begin
        c_r <= '0;
        r_r <= r_r + RUN_W'(1);
      end else begin
        c_r <= c_r + RUN_W'(1);
      end
    end
    if (cmd.mul) begin
      prod_r <= (op_r == OP_CLEAR) ? PROD_W'(stride_r) * PROD_W'(rows_r)
                                   : PROD_W'(row_sel) * PROD_W'(stride_r);
    end
    if (cmd.chk) begin
      addr_r <= addr_sum;
      inr_r  <= addr_sum < SUM_W'(DEPTH);
    end
    if (cmd.clr_start) begin
      n_r   <= (prod_r > PROD_W'(DEPTH)) ? CW'(DEPTH) : CW'(prod_r);
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + CW'(1);
    end
  end

  // blit run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r   <= '0;
      by_r   <= '0;
      bw_r   <= '0;
      bh_r   <= '0;
      bc_r   <= '0;
      br_r   <= '0;
      bkey_r <= '0;
      bwt_r  <= '0;
      bact_r <= 1'b0;
    end else if (cmd.blit_set) begin
      bx_r   <= px_r;
      by_r   <= py_r;
      bw_r   <= w_r;
      bh_r   <= h_r;
      bc_r   <= '0;
      br_r   <= '0;
      bkey_r <= key_r;
      bwt_r  <= a_r;
      bact_r <= (w_r != '0) && (h_r != '0);
    end else if (cmd.blit_adv) begin
      if (bc_inc >= bw_r) begin
        bc_r <= '0;
        br_r <= br_inc;
        if (br_inc >= bh_r) bact_r <= 1'b0;
      end else begin
        bc_r <= bc_inc;
      end
    end
  end

  // result accumulation and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load) begin
      res_rv_r <= '0;
      res_st_r <= ST_OK;
      res_wr_r <= '0;
    end else begin
      if (cmd.no_blit) res_st_r <= ST_NOBLIT;
      if (cmd.wr) begin
        if (inr_r) res_wr_r <= res_wr_r + WCNT_W'(1);
        else       res_st_r <= ST_OOR;
      end
      if (cmd.rd_cap) begin
        if (inr_r) res_rv_r <= rd_r;
        else       res_st_r <= ST_OOR;
      end
      if (cmd.clr_start) begin
        res_wr_r <= (prod_r > PROD_W'(DEPTH)) ? WCNT_W'(DEPTH) : WCNT_W'(prod_r);
        if (prod_r > PROD_W'(DEPTH)) res_st_r <= ST_OOR;
      end
    end
    if (cmd.out_load) begin
      out_rv_r <= res_rv_r;
      out_st_r <= res_st_r;
      out_wr_r <= res_wr_r;
    end
  end

  assign stat.op          = op_r;
  assign stat.zero_fill   = (wt_sel == '0) || (w_r == '0) || (h_r == '0);
  assign stat.fill_last   = (c_r == w_r - RUN_W'(1)) && (r_r == h_r - RUN_W'(1));
  assign stat.blit_active = bact_r;
  assign stat.skip_px     = (color_r == bkey_r) || (bwt_r == '0);
  assign stat.clr_empty   = (prod_r == '0);
  assign stat.clr_last    = (clr_r == n_r - CW'(1));
  assign stat.out_valid   = out_valid_r;

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_rv_r;
  assign out_status         = out_st_r;
  assign out_pixels_written = out_wr_r;

  a_wr_inrange: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && mem_we) |-> (addr_r < SUM_W'(DEPTH)))
    else $error("frame store written outside its depth");

endmodule

@@ src/rgb565_blit_fill_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_blit_fill_engine
// RGB565 frame store with pixel, fill, alpha fill, keyed blit, clear and read.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. Every pixel access runs
// through the frame store as address multiply, range check with registered
// read, then blend and write or, for a read, capture. Set pixel, a written
// blit pixel and a read each go through these steps once; blit begin, a blit
// pixel that is keyed out or has zero weight, a blit pixel with no blit
// running and the unused code skip them; a fill goes through them for each
// of its width*height pixels (not at all when it writes nothing), and a
// clear zeroes min(row_stride*screen_rows, SCREEN_W*SCREEN_H) store
// addresses, one store address per cycle. A result that waits on out_ready
// holds the block for as long as it waits. The store has no reset: reading
// a pixel never written returns whatever the memory holds. A write that
// lands at or beyond SCREEN_W*SCREEN_H is dropped and status reports 1.
// Configuration writes take effect at once and belong only in idle time.
module rgb565_blit_fill_engine
  import rbf_pkg::*;
#(
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [COORD_W-1:0] in_pos_x,
  input  logic [COORD_W-1:0] in_pos_y,
  input  logic [RUN_W-1:0]   in_rect_width,
  input  logic [RUN_W-1:0]   in_rect_height,
  input  logic [PIX_W-1:0]   in_pixel_color,
  input  logic [ALPHA_W-1:0] in_alpha,
  input  logic [PIX_W-1:0]   in_key_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_read_value,
  output logic [STAT_W-1:0]  out_status,
  output logic [WCNT_W-1:0]  out_pixels_written,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  rbf_cmd_t  cmd;   // sequencer steps
  rbf_stat_t stat;  // decode and loop flags back

  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbf_datapath #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_rect_width      (in_rect_width),
    .in_rect_height     (in_rect_height),
    .in_pixel_color     (in_pixel_color),
    .in_alpha           (in_alpha),
    .in_key_color       (in_key_color),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_value     (out_read_value),
    .out_status         (out_status),
    .out_pixels_written (out_pixels_written)
  );

endmodule
